[hdl/line_raster_folded_address_assert.svh]
// assertion macros for the line raster checker
// used by lrfa_checker, expects clk and rst in the including scope
`ifndef LINE_RASTER_FOLDED_ADDRESS_ASSERT_SVH
`define LINE_RASTER_FOLDED_ADDRESS_ASSERT_SVH

// same-cycle implication
`define LRFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line raster check failed");

// next-cycle implication
`define LRFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line raster check failed");

`endif

[hdl/lrfa_pkg.sv]
// types and constants shared by the line raster blocks
// no dependencies
`timescale 1ns / 1ps

package lrfa_pkg;

  localparam int COORD_W = 16;
  localparam int SIZE_W  = 13;
  localparam int PIX_W   = 12;
  localparam int ADDR_W  = 24;
  localparam int COLOR_W = 8;
  localparam int PROD_W  = PIX_W + SIZE_W;
  localparam int T_W     = COORD_W + 2;
  localparam int MAG_W   = T_W - 1;
  localparam int CNT_W   = $clog2(MAG_W + 1);
  localparam int SIZE_MAX = 4096;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef struct packed {
    logic                      vres;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic                      last;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FOLD,
    BK_MUL,
    BK_SEND
  } back_state_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] s;
    if (r == '0) begin
      s = SIZE_W'(1);
    end else if (r > SIZE_W'(SIZE_MAX)) begin
      s = SIZE_W'(SIZE_MAX);
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

[hdl/lrfa_in_if.sv]
// request channel into the line raster
// depends on lrfa_pkg
`timescale 1ns / 1ps

interface lrfa_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [lrfa_pkg::COORD_W-1:0] x_start;
  logic signed [lrfa_pkg::COORD_W-1:0] y_start;
  logic signed [lrfa_pkg::COORD_W-1:0] x_end;
  logic signed [lrfa_pkg::COORD_W-1:0] y_end;
  logic [lrfa_pkg::COLOR_W-1:0]        line_color;

  modport source (output valid, action, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink (input valid, action, x_start, y_start, x_end, y_end, line_color,
                output ready);
endinterface

[hdl/lrfa_out_if.sv]
// pixel channel out of the line raster
// depends on lrfa_pkg
`timescale 1ns / 1ps

interface lrfa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         valid_res;
  logic [lrfa_pkg::PIX_W-1:0]   pixel_x;
  logic [lrfa_pkg::PIX_W-1:0]   pixel_y;
  logic [lrfa_pkg::ADDR_W-1:0]  pixel_address;
  logic [lrfa_pkg::COLOR_W-1:0] pixel_color;
  logic                         last;

  modport source (output valid, valid_res, pixel_x, pixel_y, pixel_address, pixel_color,
                  last, input ready);
  modport sink (input valid, valid_res, pixel_x, pixel_y, pixel_address, pixel_color,
                last, output ready);
endinterface

[hdl/lrfa_front.sv]
// front end: takes requests and runs the bresenham walk, one queue entry per request
// depends on lrfa_pkg and lrfa_in_if
`timescale 1ns / 1ps

module lrfa_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  lrfa_in_if.sink              cmd,
  input  logic                 q_full,
  output logic                 push,
  output lrfa_pkg::entry_t     push_entry
);

  localparam int SPAN_W = COORD_BITS + 1;
  localparam int ERR_W  = COORD_BITS + 3;
  localparam int E2_W   = COORD_BITS + 4;

  logic signed [COORD_BITS-1:0] cur_x, cur_y, goal_x, goal_y;
  logic signed [SPAN_W-1:0]     span_x, span_y;
  logic [1:0]                   step_dirs;
  logic signed [ERR_W-1:0]      error_term;
  logic [lrfa_pkg::COLOR_W-1:0] held_color;
  logic                         active;

  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic signed [SPAN_W-1:0]     dx, dy, sx, sy;
  logic signed [E2_W-1:0]       e2;
  logic                         step_x, step_y;
  logic signed [COORD_BITS-1:0] cx_adv, cy_adv;
  logic signed [ERR_W-1:0]      err_adv;
  logic                         is_start, adv_last;
  logic                         accept;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && !q_full;
  assign is_start  = (cmd.action == lrfa_pkg::ACT_START);

  always_comb begin
    x0 = cmd.x_start[COORD_BITS-1:0];
    y0 = cmd.y_start[COORD_BITS-1:0];
    x1 = cmd.x_end[COORD_BITS-1:0];
    y1 = cmd.y_end[COORD_BITS-1:0];
    dx = SPAN_W'(x1) - SPAN_W'(x0);
    dy = SPAN_W'(y1) - SPAN_W'(y0);
    sx = dx[SPAN_W-1] ? -dx : dx;
    sy = dy[SPAN_W-1] ? -dy : dy;

    e2     = E2_W'(error_term) <<< 1;
    step_x = e2 > -E2_W'(span_y);
    step_y = e2 < E2_W'(span_x);
    err_adv = error_term;
    cx_adv  = cur_x;
    cy_adv  = cur_y;
    if (step_x) begin
      err_adv = err_adv - ERR_W'(span_y);
      cx_adv  = step_dirs[0] ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
    end
    if (step_y) begin
      err_adv = err_adv + ERR_W'(span_x);
      cy_adv  = step_dirs[1] ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
    end
    adv_last = (cx_adv == goal_x) && (cy_adv == goal_y);

    push = accept;
    if (is_start) begin
      push_entry.vres  = 1'b1;
      push_entry.x     = lrfa_pkg::COORD_W'(x0);
      push_entry.y     = lrfa_pkg::COORD_W'(y0);
      push_entry.color = cmd.line_color;
      push_entry.last  = (x0 == x1) && (y0 == y1);
    end else if (active) begin
      push_entry.vres  = 1'b1;
      push_entry.x     = lrfa_pkg::COORD_W'(cx_adv);
      push_entry.y     = lrfa_pkg::COORD_W'(cy_adv);
      push_entry.color = held_color;
      push_entry.last  = adv_last;
    end else begin
      push_entry = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      span_x     <= '0;
      span_y     <= '0;
      step_dirs  <= '0;
      error_term <= '0;
      held_color <= '0;
      active     <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        cur_x      <= x0;
        cur_y      <= y0;
        goal_x     <= x1;
        goal_y     <= y1;
        span_x     <= sx;
        span_y     <= sy;
        step_dirs  <= {!(y0 < y1), !(x0 < x1)};
        error_term <= ERR_W'(sx) - ERR_W'(sy);
        held_color <= cmd.line_color;
        active     <= !((x0 == x1) && (y0 == y1));
      end else if (active) begin
        cur_x      <= cx_adv;
        cur_y      <= cy_adv;
        error_term <= err_adv;
        active     <= !adv_last;
      end
    end
  end

endmodule

[hdl/lrfa_queue.sv]
// short queue of stepped pixels between front and back
// depends on lrfa_pkg
`timescale 1ns / 1ps

module lrfa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lrfa_pkg::entry_t push_entry,
  output logic             full,
  output logic             avail,
  output lrfa_pkg::entry_t head,
  input  logic             pop
);

  lrfa_pkg::entry_t slots [lrfa_pkg::Q_DEPTH];
  logic [lrfa_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [lrfa_pkg::Q_CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full    = (count == lrfa_pkg::Q_CNT_W'(lrfa_pkg::Q_DEPTH));
  assign avail   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == lrfa_pkg::Q_PTR_W'(lrfa_pkg::Q_DEPTH - 1)) ? '0
                  : wr_ptr + lrfa_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == lrfa_pkg::Q_PTR_W'(lrfa_pkg::Q_DEPTH - 1)) ? '0
                  : rd_ptr + lrfa_pkg::Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + lrfa_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - lrfa_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/lrfa_fold.sv]
// mirror fold of one coordinate into the screen, one remainder bit per cycle
// depends on lrfa_pkg
`timescale 1ns / 1ps

module lrfa_fold (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [lrfa_pkg::COORD_W-1:0] p,
  input  logic [lrfa_pkg::SIZE_W-1:0]         size,
  output logic                                done,
  output logic [lrfa_pkg::PIX_W-1:0]          value
);

  localparam int TW = lrfa_pkg::T_W;
  localparam int MW = lrfa_pkg::MAG_W;
  localparam int SW = lrfa_pkg::SIZE_W;

  logic                          busy;
  logic [lrfa_pkg::CNT_W-1:0]    cnt;
  logic [MW-1:0]                 mag;
  logic [SW-1:0]                 rem;
  logic                          neg, over;

  logic signed [TW-1:0] t, t_neg;
  logic [SW:0]          trial;
  logic [SW-1:0]        mirrored;

  always_comb begin
    t     = TW'(p) + $signed({{(TW-SW+1){1'b0}}, size[SW-1:1]});
    t_neg = -t;
    trial = {rem, mag[MW-1]};
    mirrored = size - SW'(1) - rem;
    done  = busy && (cnt == '0);
    value = (over && !neg) ? mirrored[lrfa_pkg::PIX_W-1:0] : rem[lrfa_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= lrfa_pkg::CNT_W'(MW);
    end else if (busy && cnt != '0) begin
      cnt <= cnt - lrfa_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= t[TW-1];
      over <= !t[TW-1] && (t >= $signed({{(TW-SW){1'b0}}, size}));
      mag  <= t[TW-1] ? t_neg[MW-1:0] : t[MW-1:0];
      rem  <= '0;
    end else if (busy && cnt != '0) begin
      mag <= mag << 1;
      if (trial >= {1'b0, size}) begin
        rem <= SW'(trial - {1'b0, size});
      end else begin
        rem <= trial[SW-1:0];
      end
    end
  end

endmodule

[hdl/lrfa_back.sv]
// back end: folds both coordinates, forms the byte address, holds the output
// depends on lrfa_pkg, lrfa_out_if and lrfa_fold
`timescale 1ns / 1ps

module lrfa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_avail,
  input  lrfa_pkg::entry_t            q_head,
  output logic                        q_pop,
  input  logic [lrfa_pkg::SIZE_W-1:0] screen_width,
  input  logic [lrfa_pkg::SIZE_W-1:0] screen_height,
  lrfa_out_if.source                  pix
);

  lrfa_pkg::back_state_t state, state_next;

  lrfa_pkg::entry_t              cur;
  logic [lrfa_pkg::PIX_W-1:0]    px, py;
  logic [lrfa_pkg::PROD_W-1:0]   prod;
  logic [lrfa_pkg::SIZE_W-1:0]   w_eff, h_eff;
  logic                          fold_start, load;
  logic                          done_x, done_y;
  logic [lrfa_pkg::PIX_W-1:0]    fx, fy;
  logic                          out_valid;

  assign w_eff = lrfa_pkg::eff_size(screen_width);
  assign h_eff = lrfa_pkg::eff_size(screen_height);

  lrfa_fold u_fold_x (
    .clk   (clk),
    .rst   (rst),
    .start (fold_start),
    .p     (q_head.x),
    .size  (w_eff),
    .done  (done_x),
    .value (fx)
  );

  lrfa_fold u_fold_y (
    .clk   (clk),
    .rst   (rst),
    .start (fold_start),
    .p     (q_head.y),
    .size  (h_eff),
    .done  (done_y),
    .value (fy)
  );

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    fold_start = 1'b0;
    load       = 1'b0;
    case (state)
      lrfa_pkg::BK_IDLE: begin
        if (q_avail) begin
          q_pop = 1'b1;
          if (q_head.vres) begin
            fold_start = 1'b1;
            state_next = lrfa_pkg::BK_FOLD;
          end else begin
            state_next = lrfa_pkg::BK_SEND;
          end
        end
      end
      lrfa_pkg::BK_FOLD: begin
        if (done_x && done_y) begin
          state_next = lrfa_pkg::BK_MUL;
        end
      end
      lrfa_pkg::BK_MUL: begin
        state_next = lrfa_pkg::BK_SEND;
      end
      lrfa_pkg::BK_SEND: begin
        if (!out_valid || pix.ready) begin
          load       = 1'b1;
          state_next = lrfa_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = lrfa_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrfa_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lrfa_pkg::BK_IDLE && q_avail) begin
      cur  <= q_head;
      px   <= '0;
      py   <= '0;
      prod <= '0;
    end else if (state == lrfa_pkg::BK_FOLD && done_x && done_y) begin
      px <= fx;
      py <= fy;
    end else if (state == lrfa_pkg::BK_MUL) begin
      prod <= lrfa_pkg::PROD_W'(py) * lrfa_pkg::PROD_W'(w_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix.valid_res     <= cur.vres;
      pix.pixel_x       <= px;
      pix.pixel_y       <= py;
      pix.pixel_address <= prod[lrfa_pkg::ADDR_W-1:0] + lrfa_pkg::ADDR_W'(px);
      pix.pixel_color   <= cur.color;
      pix.last          <= cur.last;
    end
  end

  assign pix.valid = out_valid;

endmodule

[hdl/line_raster_folded_address.sv]
// line raster top level: config registers, front end, queue and back end
// depends on lrfa_pkg, lrfa_in_if, lrfa_out_if, lrfa_front, lrfa_queue, lrfa_back
`timescale 1ns / 1ps

// Bresenham line stepper with a mirror-fold pixel addresser. A start request loads
// both endpoints and a color and yields the first pixel; each advance request yields
// the next pixel, with last set on the second endpoint; an advance with no line
// active yields a result with valid_res low and all other fields zero. Each pixel is
// centered, folded into the screen and turned into row * width + column. The front
// end takes one request per cycle while its two-entry queue has room; the back end
// then takes one pixel at a time, through the 17-step remainder loop of both fold
// units and a multiply. The user must write the screen size registers only while
// the block is idle (not enforced); 0 acts as 1 and values above 4096 act as 4096.

module line_raster_folded_address #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lrfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrfa_pkg::SIZE_W-1:0]        cfg_data,
  lrfa_in_if.sink                            cmd,
  lrfa_out_if.source                         pix
);

  logic [lrfa_pkg::SIZE_W-1:0] screen_width, screen_height;
  logic                        q_full, q_avail, push, q_pop;
  lrfa_pkg::entry_t            push_entry, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lrfa_pkg::WIDTH_RESET;
      screen_height <= lrfa_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lrfa_pkg::REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end
      if (cfg_index == lrfa_pkg::REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data;
      end
    end
  end

  lrfa_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lrfa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .avail      (q_avail),
    .head       (q_head),
    .pop        (q_pop)
  );

  lrfa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_avail       (q_avail),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pix           (pix)
  );

endmodule

[hdl/lrfa_checker.sv]
// port-level checks on the line raster output, bound to the top level
// depends on lrfa_pkg and line_raster_folded_address_assert.svh
`timescale 1ns / 1ps
`include "line_raster_folded_address_assert.svh"

module lrfa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         valid_res,
  input logic [lrfa_pkg::PIX_W-1:0]   pixel_x,
  input logic [lrfa_pkg::PIX_W-1:0]   pixel_y,
  input logic [lrfa_pkg::ADDR_W-1:0]  pixel_address,
  input logic [lrfa_pkg::COLOR_W-1:0] pixel_color,
  input logic                         last
);

  // stalled pixel holds
  `LRFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_address) && $stable(pixel_x) && $stable(pixel_y) && $stable(last))

  // no-pixel result carries zeros
  `LRFA_ASSERT_NOW(a_empty_zero, out_valid && !valid_res, pixel_x == '0 && pixel_y == '0 && pixel_address == '0 && pixel_color == '0 && !last)

  // end of line only on a real pixel
  `LRFA_ASSERT_NOW(a_last_real, out_valid && last, valid_res)

endmodule

bind line_raster_folded_address lrfa_checker u_lrfa_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (pix.valid),
  .out_ready     (pix.ready),
  .valid_res     (pix.valid_res),
  .pixel_x       (pix.pixel_x),
  .pixel_y       (pix.pixel_y),
  .pixel_address (pix.pixel_address),
  .pixel_color   (pix.pixel_color),
  .last          (pix.last)
);
